/* rtl/gas_pkg.sv */
package gas_pkg;

	localparam int VERTEX_W         = 6;
	localparam int VERTEX_SPAN      = 64;
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_DEGREE   = 16;
	localparam int VCOUNT_W         = 7;
	localparam int EDGE_W           = 10;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
	localparam logic [EDGE_W-1:0]   EDGE_MAX     = 10'd1023;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_FULL = 2'd2
	} status_code_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_ADD_B,
		S_ADD_CHK,
		S_ADD_WB,
		S_STRIP_DEG,
		S_STRIP_SCAN,
		S_STRIP_FIN,
		S_Q_DEG,
		S_Q_OUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
	} request_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [VERTEX_W-1:0] neighbor;
		logic                neighbor_valid;
		logic                last;
		logic [EDGE_W-1:0]   edge_total;
	} result_t;

	typedef struct packed {
		logic         load;
		logic         deg_rd_b;
		logic         cap_da;
		logic         cap_db;
		logic         wr_a;
		logic         wr_b;
		logic         edge_inc;
		logic         edge_dec;
		logic         scan_init;
		logic         scan_step;
		logic         keep_write;
		logic         strip_fin;
		logic         emit;
		logic         emit_nb;
		logic         emit_last;
		status_code_t emit_status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic bad;
		op_t  op;
		logic full;
		logic deg_zero;
		logic scan_last;
		logic second;
	} ctrl_stat_t;

endpackage

/* rtl/gas_ram.sv */
module gas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/gas_ctrl.sv */
module gas_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  gas_pkg::ctrl_stat_t   stat,
	output gas_pkg::ctrl_cmd_t    cmd,
	output logic                  busy
);

	gas_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gas_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != gas_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gas_pkg::S_IDLE: begin
				if (start) state_d = gas_pkg::S_CHECK;
			end
			gas_pkg::S_CHECK: begin
				if (stat.bad) state_d = gas_pkg::S_IDLE;
				else if (stat.op == gas_pkg::OP_ADD) state_d = gas_pkg::S_ADD_B;
				else if (stat.op == gas_pkg::OP_REMOVE) state_d = gas_pkg::S_STRIP_DEG;
				else state_d = gas_pkg::S_Q_DEG;
			end
			gas_pkg::S_ADD_B: begin
				state_d = gas_pkg::S_ADD_CHK;
			end
			gas_pkg::S_ADD_CHK: begin
				state_d = stat.full ? gas_pkg::S_IDLE : gas_pkg::S_ADD_WB;
			end
			gas_pkg::S_ADD_WB: begin
				state_d = gas_pkg::S_DONE;
			end
			gas_pkg::S_STRIP_DEG: begin
				state_d = stat.deg_zero ? gas_pkg::S_STRIP_FIN : gas_pkg::S_STRIP_SCAN;
			end
			gas_pkg::S_STRIP_SCAN: begin
				if (stat.scan_last) state_d = gas_pkg::S_STRIP_FIN;
			end
			gas_pkg::S_STRIP_FIN: begin
				state_d = stat.second ? gas_pkg::S_DONE : gas_pkg::S_STRIP_DEG;
			end
			gas_pkg::S_Q_DEG: begin
				state_d = stat.deg_zero ? gas_pkg::S_IDLE : gas_pkg::S_Q_OUT;
			end
			gas_pkg::S_Q_OUT: begin
				if (stat.scan_last) state_d = gas_pkg::S_IDLE;
			end
			gas_pkg::S_DONE: begin
				state_d = gas_pkg::S_IDLE;
			end
			default: begin
				state_d = gas_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_status = gas_pkg::STAT_OK;
		unique case (state_q)
			gas_pkg::S_IDLE: begin
				cmd.load = start;
			end
			gas_pkg::S_CHECK: begin
				if (stat.bad) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = gas_pkg::STAT_BAD;
				end
			end
			gas_pkg::S_ADD_B: begin
				cmd.cap_da   = 1'b1;
				cmd.deg_rd_b = 1'b1;
			end
			gas_pkg::S_ADD_CHK: begin
				if (stat.full) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = gas_pkg::STAT_FULL;
				end else begin
					cmd.cap_db = 1'b1;
					cmd.wr_a   = 1'b1;
				end
			end
			gas_pkg::S_ADD_WB: begin
				cmd.wr_b     = 1'b1;
				cmd.edge_inc = 1'b1;
			end
			gas_pkg::S_STRIP_DEG: begin
				cmd.scan_init = 1'b1;
			end
			gas_pkg::S_STRIP_SCAN: begin
				cmd.scan_step  = 1'b1;
				cmd.keep_write = 1'b1;
			end
			gas_pkg::S_STRIP_FIN: begin
				cmd.strip_fin = 1'b1;
				cmd.deg_rd_b  = !stat.second;
				cmd.edge_dec  = stat.second;
			end
			gas_pkg::S_Q_DEG: begin
				cmd.scan_init = 1'b1;
				if (stat.deg_zero) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
				end
			end
			gas_pkg::S_Q_OUT: begin
				cmd.scan_step = 1'b1;
				cmd.emit      = 1'b1;
				cmd.emit_nb   = 1'b1;
				cmd.emit_last = stat.scan_last;
			end
			gas_pkg::S_DONE: begin
				cmd.emit      = 1'b1;
				cmd.emit_last = 1'b1;
			end
			default: begin
				cmd.emit_status = gas_pkg::STAT_OK;
			end
		endcase
	end

endmodule

/* rtl/gas_datapath.sv */
module gas_datapath #(
	parameter int MAX_VERTICES = gas_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DEGREE   = gas_pkg::DEF_MAX_DEGREE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gas_pkg::request_t             request,
	input  logic                          cfg_we,
	input  logic [gas_pkg::VCOUNT_W-1:0]  cfg_data,
	input  gas_pkg::ctrl_cmd_t            cmd,
	output gas_pkg::ctrl_stat_t           stat,
	output gas_pkg::result_t              result,
	output logic                          strobe
);

	localparam int ROWS     = (MAX_VERTICES < gas_pkg::VERTEX_SPAN) ?
	                          MAX_VERTICES : gas_pkg::VERTEX_SPAN;
	localparam int RW       = $clog2(ROWS);
	localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
	localparam int NT_DEPTH = ROWS * MAX_DEGREE;
	localparam int NT_AW    = $clog2(NT_DEPTH);
	localparam int VW       = gas_pkg::VERTEX_W;

	localparam logic [DEG_W-1:0] DEG_FULL = DEG_W'(MAX_DEGREE);
	localparam logic [DEG_W-1:0] DEG_ONE  = DEG_W'(1);

	function automatic logic [NT_AW-1:0] nt_addr(input logic [RW-1:0] row,
	                                              input logic [DEG_W-1:0] slot);
		return NT_AW'(int'(row) * MAX_DEGREE + int'(slot));
	endfunction

	gas_pkg::request_t             req_q;
	logic                          second_q;
	logic [gas_pkg::VCOUNT_W-1:0]  vcount_q;
	logic [gas_pkg::EDGE_W-1:0]    edge_q;
	logic [DEG_W-1:0]              da_q, db_q, d_q, idx_q, w_q;
	logic [ROWS-1:0]               deg_vld_q;
	logic                          deg_vld_s1;
	gas_pkg::result_t              result_q;
	logic                          strobe_q;

	logic [RW-1:0]    row_a, row_b, owner_row, deg_raddr, deg_waddr;
	logic [VW-1:0]    target;
	logic [DEG_W-1:0] deg_ram_rd, deg_rd, deg_wdata, rd_slot;
	logic             deg_we;
	logic [NT_AW-1:0] nt_raddr, nt_waddr;
	logic [VW-1:0]    nt_rd, nt_wdata;
	logic             nt_we, keep;
	logic             ok_a, ok_b;

	assign row_a     = RW'(req_q.vertex_a);
	assign row_b     = RW'(req_q.vertex_b);
	assign owner_row = second_q ? row_b : row_a;
	assign target    = second_q ? req_q.vertex_a : req_q.vertex_b;

	assign ok_a = ({1'b0, req_q.vertex_a} < vcount_q) && (int'(req_q.vertex_a) < MAX_VERTICES);
	assign ok_b = ({1'b0, req_q.vertex_b} < vcount_q) && (int'(req_q.vertex_b) < MAX_VERTICES);

	assign deg_raddr = cmd.deg_rd_b ? row_b : row_a;
	assign deg_rd    = deg_vld_s1 ? deg_ram_rd : '0;

	always_comb begin
		deg_we    = cmd.wr_a | cmd.wr_b | cmd.strip_fin;
		deg_waddr = owner_row;
		deg_wdata = w_q;
		priority if (cmd.wr_a) begin
			deg_waddr = row_a;
			deg_wdata = DEG_W'(da_q + DEG_ONE);
		end else if (cmd.wr_b) begin
			deg_waddr = row_b;
			deg_wdata = DEG_W'(db_q + DEG_ONE);
		end
	end

	assign rd_slot  = cmd.scan_init ? '0 : DEG_W'(idx_q + DEG_ONE);
	assign nt_raddr = nt_addr(owner_row, rd_slot);
	assign keep     = cmd.keep_write && (nt_rd != target);

	always_comb begin
		nt_we    = keep;
		nt_waddr = nt_addr(owner_row, w_q);
		nt_wdata = nt_rd;
		priority if (cmd.wr_a) begin
			nt_we    = 1'b1;
			nt_waddr = nt_addr(row_a, da_q);
			nt_wdata = req_q.vertex_b;
		end else if (cmd.wr_b) begin
			nt_we    = 1'b1;
			nt_waddr = nt_addr(row_b, db_q);
			nt_wdata = req_q.vertex_a;
		end
	end

	gas_ram #(.WIDTH(DEG_W), .DEPTH(ROWS)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (deg_raddr),
		.rdata (deg_ram_rd)
	);

	gas_ram #(.WIDTH(VW), .DEPTH(NT_DEPTH)) u_nbr_ram (
		.clk   (clk),
		.we    (nt_we),
		.waddr (nt_waddr),
		.wdata (nt_wdata),
		.raddr (nt_raddr),
		.rdata (nt_rd)
	);

	always_comb begin
		stat.op        = gas_pkg::op_t'(req_q.op);
		stat.full      = (da_q == DEG_FULL) || (deg_rd == DEG_FULL);
		stat.deg_zero  = (deg_rd == '0);
		stat.scan_last = (idx_q == DEG_W'(d_q - DEG_ONE));
		stat.second    = second_q;
		unique case (gas_pkg::op_t'(req_q.op))
			gas_pkg::OP_ADD, gas_pkg::OP_REMOVE: begin
				stat.bad = !ok_a || !ok_b || (req_q.vertex_a == req_q.vertex_b);
			end
			gas_pkg::OP_QUERY: begin
				stat.bad = !ok_a;
			end
			default: begin
				stat.bad = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= gas_pkg::VCOUNT_RESET;
			edge_q     <= '0;
			deg_vld_q  <= '0;
			deg_vld_s1 <= 1'b0;
			second_q   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (cfg_we) vcount_q <= cfg_data;
			if (cmd.edge_inc && edge_q != gas_pkg::EDGE_MAX) begin
				edge_q <= edge_q + 1'b1;
			end else if (cmd.edge_dec && edge_q != '0) begin
				edge_q <= edge_q - 1'b1;
			end
			if (deg_we) deg_vld_q[deg_waddr] <= 1'b1;
			deg_vld_s1 <= deg_vld_q[deg_raddr];
			if (cmd.load) begin
				second_q <= 1'b0;
			end else if (cmd.strip_fin) begin
				second_q <= 1'b1;
			end
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= request;
		if (cmd.cap_da) da_q <= deg_rd;
		if (cmd.cap_db) db_q <= deg_rd;
		if (cmd.scan_init) begin
			d_q   <= deg_rd;
			idx_q <= '0;
			w_q   <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= DEG_W'(idx_q + DEG_ONE);
			if (keep) w_q <= DEG_W'(w_q + DEG_ONE);
		end
		if (cmd.emit) begin
			result_q.status         <= cmd.emit_status;
			result_q.neighbor       <= cmd.emit_nb ? nt_rd : '0;
			result_q.neighbor_valid <= cmd.emit_nb;
			result_q.last           <= cmd.emit_last;
			result_q.edge_total     <= edge_q;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

/* rtl/graph_adjacency_store_unit.sv */
// Results per command: reject, list full, add and remove give one word each; a query
// with d neighbors gives d words back to back (empty list: one word).
// Throughput: one command at a time; start is taken again in the cycle of the last
// strobe. Remove and query walk the neighbor RAM one slot per cycle (one read port).
// arst_n clears control, edge count, degree valid bits and sets vertex_count to 64.
// Results cannot be stalled: each word is shown for exactly one cycle.
module graph_adjacency_store_unit #(
	parameter int MAX_VERTICES = gas_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DEGREE   = gas_pkg::DEF_MAX_DEGREE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  gas_pkg::request_t            request,
	output logic                         busy,
	output gas_pkg::result_t             result,
	output logic                         strobe,
	input  logic                         cfg_we,
	input  logic [gas_pkg::VCOUNT_W-1:0] cfg_data
);

	gas_pkg::ctrl_cmd_t  cmd;
	gas_pkg::ctrl_stat_t stat;

	gas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gas_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_DEGREE   (MAX_DEGREE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result),
		.strobe   (strobe)
	);

endmodule

/* rtl/gas_checker.sv */
module gas_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input gas_pkg::result_t  result,
	input logic              strobe
);

	// query words stream back to back
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("query stream broken");

	a_busy_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (busy == !result.last))
		else $error("busy does not match last word");

	a_nb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.neighbor_valid |-> result.neighbor == '0)
		else $error("neighbor not zero");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != gas_pkg::STAT_OK |-> result.last && !result.neighbor_valid)
		else $error("error word not single");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

endmodule

bind graph_adjacency_store_unit gas_checker u_gas_checker (.*);

/* sim/adjacency_checker.sv */
module adjacency_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  gas_pkg::request_t            request,
	input  logic                         strobe,
	input  gas_pkg::result_t             result,
	input  logic                         cfg_we,
	input  logic [gas_pkg::VCOUNT_W-1:0] cfg_data,
	output int                           mismatch_count,
	output int                           pending,
	output int                           word_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VERTICES = gas_pkg::DEF_MAX_VERTICES;
	localparam int DEGREE   = gas_pkg::DEF_MAX_DEGREE;

	logic [gas_pkg::VERTEX_W-1:0] nbr_list [VERTICES][DEGREE];
	logic [4:0]                   nbr_count [VERTICES];
	logic [gas_pkg::EDGE_W-1:0]   edge_level;
	logic [gas_pkg::VCOUNT_W-1:0] live_vertices;
	gas_pkg::result_t             awaited_words [$];
	gas_pkg::result_t             want_word;

	task automatic flag(input string what, input int got, input int want);
		mismatch_count++;
		$display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic enqueue_word(input gas_pkg::result_t w);
		awaited_words = {awaited_words, w};
	endtask

	// Close the gaps left by deleting every copy of target from owner's list.
	task automatic drop_copies(input int owner, input int target);
		int kept;
		kept = 0;
		for (int i = 0; i < nbr_count[owner]; i++) begin
			if (nbr_list[owner][i] != target) begin
				nbr_list[owner][kept] = nbr_list[owner][i];
				kept++;
			end
		end
		for (int i = kept; i < DEGREE; i++) begin
			nbr_list[owner][i] = '0;
		end
		nbr_count[owner] = 5'(kept);
	endtask

	task automatic apply_command(input gas_pkg::request_t cmd);
		gas_pkg::op_t     op;
		int               a;
		int               b;
		int               da;
		int               db;
		gas_pkg::result_t word;
		op = gas_pkg::op_t'(cmd.op);
		a = cmd.vertex_a;
		b = cmd.vertex_b;
		word = '0;
		word.last = 1'b1;
		if (op == gas_pkg::OP_QUERY && a < live_vertices && nbr_count[a] != 0) begin
			for (int i = 0; i < nbr_count[a]; i++) begin
				word.status = gas_pkg::STAT_OK;
				word.neighbor = nbr_list[a][i];
				word.neighbor_valid = 1'b1;
				word.last = (i == nbr_count[a] - 1);
				word.edge_total = edge_level;
				enqueue_word(word);
			end
		end else begin
			case (op)
				gas_pkg::OP_ADD, gas_pkg::OP_REMOVE: begin
					if (a >= live_vertices || b >= live_vertices || a == b) begin
						word.status = gas_pkg::STAT_BAD;
					end else if (op == gas_pkg::OP_ADD) begin
						da = nbr_count[a];
						db = nbr_count[b];
						if (da >= DEGREE || db >= DEGREE) begin
							word.status = gas_pkg::STAT_FULL;
						end else begin
							nbr_list[a][da] = 6'(b);
							nbr_count[a] = 5'(da + 1);
							nbr_list[b][db] = 6'(a);
							nbr_count[b] = 5'(db + 1);
							if (edge_level != gas_pkg::EDGE_MAX) begin
								edge_level++;
							end
						end
					end else begin
						drop_copies(a, b);
						drop_copies(b, a);
						if (edge_level != '0) begin
							edge_level--;
						end
					end
				end
				gas_pkg::OP_QUERY: begin
					if (a >= live_vertices) begin
						word.status = gas_pkg::STAT_BAD;
					end
				end
				default: begin
					word.status = gas_pkg::STAT_BAD;
				end
			endcase
			word.edge_total = edge_level;
			enqueue_word(word);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VERTICES; v++) begin
				nbr_count[v] = '0;
				for (int i = 0; i < DEGREE; i++) begin
					nbr_list[v][i] = '0;
				end
			end
			edge_level = '0;
			live_vertices = gas_pkg::VCOUNT_RESET;
			awaited_words.delete();
			mismatch_count = 0;
			word_count = 0;
			pending = 0;
		end else begin
			if (strobe === 1'b1) begin
				word_count++;
				if (awaited_words.size() == 0) begin
					flag("word with nothing expected", result.neighbor, 0);
				end else begin
					want_word = awaited_words.pop_front();
					if (result.status !== want_word.status) begin
						flag("status", result.status, want_word.status);
					end
					if (result.neighbor !== want_word.neighbor) begin
						flag("neighbor", result.neighbor, want_word.neighbor);
					end
					if (result.neighbor_valid !== want_word.neighbor_valid) begin
						flag("neighbor_valid", result.neighbor_valid,
							want_word.neighbor_valid);
					end
					if (result.last !== want_word.last) begin
						flag("last", result.last, want_word.last);
					end
					if (result.edge_total !== want_word.edge_total) begin
						flag("edge_total", result.edge_total, want_word.edge_total);
					end
				end
			end
			if (cfg_we === 1'b1) begin
				live_vertices = cfg_data;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				apply_command(request);
			end
			pending = awaited_words.size();
		end
	end

endmodule

/* sim/tb_graph_adjacency_store_unit.sv */
module tb_graph_adjacency_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	gas_pkg::request_t            request;
	logic                         busy;
	gas_pkg::result_t             result;
	logic                         strobe;
	logic                         cfg_we;
	logic [gas_pkg::VCOUNT_W-1:0] cfg_data;

	int mismatch_count;
	int pending;
	int word_count;
	int cycle_count;
	int commands_sent;
	int cfg_writes;
	bit idling_on;

	graph_adjacency_store_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.busy     (busy),
		.result   (result),
		.strobe   (strobe),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	adjacency_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.strobe         (strobe),
		.result         (result),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending        (pending),
		.word_count     (word_count)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
		$display("== FAIL ==");
		$finish;
	end

	function automatic gas_pkg::request_t mk(input gas_pkg::op_t op, input int a,
	                                         input int b);
		gas_pkg::request_t r;
		r.op = op;
		r.vertex_a = 6'(a);
		r.vertex_b = 6'(b);
		return r;
	endfunction

	// Mostly legal vertices, often from a small pool so edges collide, some from anywhere.
	function automatic int pick_vertex(input int vc);
		int u;
		u = $urandom_range(0, 9);
		if (u == 0) begin
			return $urandom_range(0, 63);
		end
		if (u < 5) begin
			return $urandom_range(0, (vc < 8 ? vc : 8) - 1);
		end
		return $urandom_range(0, vc - 1);
	endfunction

	function automatic gas_pkg::request_t random_command(input int vc);
		int           r;
		gas_pkg::op_t op;
		r = $urandom_range(0, 99);
		if (r < 42) begin
			op = gas_pkg::OP_ADD;
		end else if (r < 62) begin
			op = gas_pkg::OP_REMOVE;
		end else if (r < 94) begin
			op = gas_pkg::OP_QUERY;
		end else if (r < 97) begin
			op = gas_pkg::OP_RSVD;
		end else begin
			op = gas_pkg::op_t'($urandom_range(0, 3));
		end
		return mk(op, pick_vertex(vc), pick_vertex(vc));
	endfunction

	task automatic issue(input gas_pkg::request_t cmd);
		if (idling_on && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		request <= cmd;
		do @(posedge clk); while (busy !== 1'b0);
		commands_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_vertex_count(input int n);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= 7'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	initial begin
		int vc_plan [6];
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_data = gas_pkg::VCOUNT_RESET;
		arst_n = 1'b0;
		cycle_count = 0;
		commands_sent = 0;
		cfg_writes = 0;
		idling_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk(gas_pkg::OP_REMOVE, 0, 1));
		issue(mk(gas_pkg::OP_QUERY, 0, 63));
		issue(mk(gas_pkg::OP_ADD, 0, 63));
		issue(mk(gas_pkg::OP_ADD, 63, 0));
		issue(mk(gas_pkg::OP_ADD, 0, 1));
		issue(mk(gas_pkg::OP_QUERY, 0, 0));
		issue(mk(gas_pkg::OP_QUERY, 63, 0));
		issue(mk(gas_pkg::OP_ADD, 5, 5));
		issue(mk(gas_pkg::OP_RSVD, 63, 63));
		issue(mk(gas_pkg::OP_REMOVE, 63, 0));
		issue(mk(gas_pkg::OP_QUERY, 0, 0));
		issue(mk(gas_pkg::OP_REMOVE, 2, 3));
		issue(mk(gas_pkg::OP_QUERY, 63, 0));

		set_vertex_count(37);
		issue(mk(gas_pkg::OP_ADD, 36, 0));
		issue(mk(gas_pkg::OP_ADD, 37, 0));
		issue(mk(gas_pkg::OP_ADD, 0, 37));
		issue(mk(gas_pkg::OP_QUERY, 37, 0));
		issue(mk(gas_pkg::OP_QUERY, 36, 0));
		issue(mk(gas_pkg::OP_REMOVE, 36, 37));

		set_vertex_count(1);
		issue(mk(gas_pkg::OP_ADD, 0, 1));
		issue(mk(gas_pkg::OP_QUERY, 0, 0));
		issue(mk(gas_pkg::OP_QUERY, 1, 0));

		// Duplicates fill both lists; one remove clears them all but counts one edge.
		set_vertex_count(64);
		for (int round = 0; round < 2; round++) begin
			for (int k = 0; k < 17; k++) begin
				issue(mk(gas_pkg::OP_ADD, 40, 41));
			end
			issue(mk(gas_pkg::OP_QUERY, 40, 0));
			issue(mk(gas_pkg::OP_REMOVE, 41, 40));
		end
		issue(mk(gas_pkg::OP_ADD, 40, 41));
		issue(mk(gas_pkg::OP_QUERY, 41, 0));

		vc_plan = '{64, 5, 1, 37, $urandom_range(2, 63), 64};
		for (int phase = 0; phase < 6; phase++) begin
			set_vertex_count(vc_plan[phase]);
			idling_on = (phase != 0);
			for (int n = 0; n < 62; n++) begin
				issue(random_command(vc_plan[phase]));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("%0d commands over %0d vertex-count settings, %0d result words checked;",
			commands_sent, cfg_writes, word_count);
		$display("included full lists, duplicate edges, self loops, reserved op, empty lists.");
		if (mismatch_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
